### sv/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FACD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset cycles included.
`define FACD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/facd_pkg.sv
// Types, constants and the command lookup for the framed ASCII command decoder.
package facd_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int BYTE_W = 8;
  localparam int CODE_W = 4;
  localparam int ARG_W = 16;
  localparam int ACC_W = 16;
  localparam int CMD_NUM = 10;

  localparam logic [BYTE_W-1:0] OPEN_BYTE = 8'h3A;   // ':'
  localparam logic [BYTE_W-1:0] CLOSE_BYTE = 8'h21;  // '!'
  localparam logic [BYTE_W-1:0] PLUS_BYTE = 8'h2B;
  localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'h2D;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h30;
  localparam logic [BYTE_W-1:0] NINE_BYTE = 8'h39;
  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
  localparam logic [BYTE_W-1:0] TAB_BYTE = 8'h09;
  localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;

  // Magnitude ceiling and positive clamp of the argument.
  localparam logic [ACC_W-1:0] MAG_LIMIT = 16'h8000;
  localparam logic [ACC_W-1:0] POS_MAX = 16'h7FFF;

  // First code whose command carries an argument.
  localparam logic [CODE_W-1:0] CODE_MINL = 4'd3;
  localparam logic [CODE_W-1:0] CODE_LAST = 4'd9;

  typedef logic [CODE_W-1:0] code_t;

  // Command words, first character in the low byte.
  localparam logic [31:0] CMD_TABLE [CMD_NUM] = '{
    32'h444E4148,  // HAND
    32'h6E696873,  // shin
    32'h756F6873,  // shou
    32'h6C6E696D,  // minl
    32'h6C78616D,  // maxl
    32'h746E696D,  // mint
    32'h7478616D,  // maxt
    32'h646E696D,  // mind
    32'h6478616D,  // maxd
    32'h6F707574   // tupo
  };

  // Argument parser phase.
  typedef enum logic [3:0] {
    PH_SKIP  = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_END   = 4'b1000
  } arg_phase_t;

  typedef struct packed {
    logic  hit;
    code_t code;
  } cmd_match_t;

  // Look up a stored command word; first matching entry wins.
  function automatic cmd_match_t match_command(input logic [31:0] word);
    cmd_match_t m;
    m.hit = 1'b0;
    m.code = '0;
    for (int k = CMD_NUM - 1; k >= 0; k--) begin
      if (word == CMD_TABLE[k]) begin
        m.hit = 1'b1;
        m.code = CODE_W'(k);
      end
    end
    return m;
  endfunction

endpackage

### sv/facd_in_if.sv
// Byte input channel of the decoder.
interface facd_in_if;
  logic                          valid;
  logic                          ready;
  logic [facd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### sv/facd_out_if.sv
// Result channel of the decoder.
interface facd_out_if;
  logic                               valid;
  logic                               ready;
  logic [facd_pkg::CODE_W-1:0]        command_code;
  logic signed [facd_pkg::ARG_W-1:0]  argument_value;

  modport source (output valid, output command_code, output argument_value, input ready);
  modport sink (input valid, input command_code, input argument_value, output ready);
endinterface

### sv/framed_ascii_command_decoder.sv
// Framed ASCII command decoder: frame tracking, argument parse and result register.
//
// Usage:
//   in_ch carries one received byte per transfer (valid/ready). A ':' opens a
//   frame, a '!' closes it; bytes inside a frame are stored up to BUFFER_DEPTH.
//   The first four stored bytes are the command, the rest a decimal argument.
//   out_ch carries one result per closing '!' whose command is one of the ten
//   known ones: command_code and the saturated 16-bit argument_value.
//   Path: a byte is held in the input register and is decoded into the result
//   register when it advances, so out_ch.valid comes from the result register
//   and is not combinational from the '!' transfer.
//   Throughput: one byte per cycle unless a pending result stalls, set by the
//   single input register stage feeding the parse logic and the result register.
//   Reset (rst_n low, synchronous): frame closed, store and parse state
//   cleared, both registers empty.
//   Receiver stall: a pending result holds in the output register; one more
//   byte is taken into the input register and waits there, then in_ch.ready
//   drops until the result is transferred.
module framed_ascii_command_decoder #(
  parameter int BUFFER_DEPTH = facd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  facd_in_if.sink           in_ch,
  facd_out_if.source        out_ch
);

  localparam int POS_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(BUFFER_DEPTH);
  localparam logic [POS_W-1:0] POS_ARG = POS_W'(4);

  // Input register
  logic                               in_vld_r, in_vld_nxt;
  logic [facd_pkg::BYTE_W-1:0]        in_byte_r;
  logic                               advance;
  logic                               in_xfer;

  // Frame and parse state
  logic                               in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]                   pos_r, pos_nxt;
  logic [31:0]                        cmd_word_r, cmd_word_nxt;
  logic [facd_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic                               neg_r, neg_nxt;
  facd_pkg::arg_phase_t               phase_r, phase_nxt;

  // Result register
  logic                               out_vld_r, out_vld_nxt;
  facd_pkg::code_t                    code_r, code_nxt;
  logic [facd_pkg::ARG_W-1:0]         arg_r, arg_nxt;

  facd_pkg::cmd_match_t               match;

  assign match = facd_pkg::match_command(cmd_word_r);

  // Advance the held byte when the result slot is free or being freed.
  assign advance = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_vld_r;
  assign out_ch.command_code = code_r;
  assign out_ch.argument_value = arg_r;

  // Decode the held byte against the frame and parse state
  always_comb begin
    logic [facd_pkg::BYTE_W-1:0] b;
    logic                        is_digit;
    logic                        is_space;
    logic                        is_sign;
    logic [facd_pkg::ACC_W+2:0]  acc_ext;
    logic [facd_pkg::ACC_W+2:0]  mag;

    b = in_byte_r;
    is_digit = (b >= facd_pkg::ZERO_BYTE) && (b <= facd_pkg::NINE_BYTE);
    is_space = (b == facd_pkg::SPACE_BYTE) ||
               ((b >= facd_pkg::TAB_BYTE) && (b <= facd_pkg::CR_BYTE));
    is_sign = (b == facd_pkg::PLUS_BYTE) || (b == facd_pkg::MINUS_BYTE);
    acc_ext = (facd_pkg::ACC_W+3)'(acc_r);
    mag = (acc_ext << 3) + (acc_ext << 1) + (facd_pkg::ACC_W+3)'(b[3:0]);

    in_frame_nxt = in_frame_r;
    pos_nxt = pos_r;
    cmd_word_nxt = cmd_word_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    phase_nxt = phase_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    code_nxt = code_r;
    arg_nxt = arg_r;

    if (advance) begin
      out_vld_nxt = 1'b0;
      if (b == facd_pkg::OPEN_BYTE) begin
        in_frame_nxt = 1'b1;
      end else if (b == facd_pkg::CLOSE_BYTE) begin
        // Close the frame, report a known command, clear the store
        in_frame_nxt = 1'b0;
        out_vld_nxt = match.hit;
        code_nxt = match.code;
        if (match.code < facd_pkg::CODE_MINL) begin
          arg_nxt = '0;
        end else if (neg_r) begin
          arg_nxt = facd_pkg::ARG_W'(-acc_r);
        end else if (acc_r > facd_pkg::POS_MAX) begin
          arg_nxt = facd_pkg::POS_MAX;
        end else begin
          arg_nxt = acc_r;
        end
        pos_nxt = '0;
        cmd_word_nxt = '0;
        acc_nxt = '0;
        neg_nxt = 1'b0;
        phase_nxt = facd_pkg::PH_SKIP;
      end else if (in_frame_r && (pos_r < POS_FULL)) begin
        // Store: command bytes first, then the argument parse
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r < POS_ARG) begin
          cmd_word_nxt[pos_r[1:0]*8 +: 8] = b;
        end else if (phase_r != facd_pkg::PH_END) begin
          if ((phase_r == facd_pkg::PH_SKIP) && is_space) begin
            phase_nxt = phase_r;
          end else if ((phase_r == facd_pkg::PH_SKIP) && is_sign) begin
            neg_nxt = (b == facd_pkg::MINUS_BYTE);
            phase_nxt = facd_pkg::PH_SIGN;
          end else if (is_digit) begin
            acc_nxt = (mag > (facd_pkg::ACC_W+3)'(facd_pkg::MAG_LIMIT)) ?
                      facd_pkg::MAG_LIMIT : facd_pkg::ACC_W'(mag);
            phase_nxt = facd_pkg::PH_DIGIT;
          end else begin
            phase_nxt = facd_pkg::PH_END;
          end
        end
      end
    end
  end

  // Input register control
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      in_frame_r <= 1'b0;
      pos_r <= '0;
      cmd_word_r <= '0;
      acc_r <= '0;
      neg_r <= 1'b0;
      phase_r <= facd_pkg::PH_SKIP;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      in_frame_r <= in_frame_nxt;
      pos_r <= pos_nxt;
      cmd_word_r <= cmd_word_nxt;
      acc_r <= acc_nxt;
      neg_r <= neg_nxt;
      phase_r <= phase_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_ch.rx_byte;
    end
    code_r <= code_nxt;
    arg_r <= arg_nxt;
  end

  // Closing byte taken, and the store back at its cleared state
  logic close_adv;
  logic store_clear;

  assign close_adv = advance && (in_byte_r == facd_pkg::CLOSE_BYTE);
  assign store_clear = (pos_r == '0) && (cmd_word_r == '0) &&
                       (phase_r == facd_pkg::PH_SKIP);

`include "assert_macros.svh"

  `FACD_ASSERT(a_code_range, out_vld_r |-> (code_r <= facd_pkg::CODE_LAST), "code out of range")
  `FACD_ASSERT(a_pos_bound, pos_r <= POS_FULL, "byte position beyond buffer depth")
  `FACD_ASSERT(a_acc_bound, acc_r <= facd_pkg::MAG_LIMIT, "argument magnitude beyond limit")
  `FACD_ASSERT(a_close_clears, close_adv |=> store_clear, "store not cleared on close")
  `FACD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_vld_r && !in_vld_r), "not empty after reset")

endmodule
